>>> sv/csfs_pkg.sv
// Package for the checksum frame sender: item codes, job record and constants.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package csfs_pkg;

    // Widths of the item fields.
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned TIMEOUT_W = 16;

    // Frame bytes and reset timeout.
    localparam logic [BYTE_W-1:0]    HDR_BYTE      = 8'h11;
    localparam logic [BYTE_W-1:0]    ACK_BYTE      = 8'h06;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1500;

    // Default depth of the job queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Input request codes.
    localparam logic [ACTION_W-1:0] ACT_START   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAYLOAD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RECV    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACK     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

    // Job kinds handed from the front to the back.
    localparam int unsigned KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_START      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START_ZERO = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD_LAST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK        = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT    = 3'd5;

    // One classified request: what to emit and the bytes it needs.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] sum;
    } job_t;

    // Index of a result within one job (up to three results).
    localparam int unsigned STEP_W = 2;

endpackage

`default_nettype wire

>>> sv/csfs_front.sv
// Front end of the checksum frame sender: accepts requests, tracks the frame
// phase, checksum and acknowledge timer, and queues jobs. Uses csfs_pkg.
`default_nettype none

module csfs_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [csfs_pkg::BYTE_W-1:0]      s_tdata,
    input  wire logic [csfs_pkg::ACTION_W-1:0]    s_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [csfs_pkg::TIMEOUT_W-1:0]   cfg_wdata,
    input  wire logic                             q_ready,
    output logic                                  q_push,
    output csfs_pkg::job_t                        q_job
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_WAIT    = 2'd2;

    localparam logic [csfs_pkg::TIMEOUT_W-1:0] WAIT_MAX = '1;

    logic [1:0]                       phase_reg, phase_next;
    logic [csfs_pkg::BYTE_W-1:0]      bytes_left_reg, bytes_left_next;
    logic [csfs_pkg::BYTE_W-1:0]      sum_reg, sum_next;
    logic [csfs_pkg::TIMEOUT_W-1:0]   wait_count_reg, wait_count_next;
    logic [csfs_pkg::TIMEOUT_W-1:0]   timeout_reg;
    logic [csfs_pkg::TIMEOUT_W-1:0]   wait_inc;
    logic                             accept;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign wait_inc = (wait_count_reg == WAIT_MAX) ? wait_count_reg
                                                   : wait_count_reg + 1'b1;

    // Classify the request against the current phase and pick the job.
    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        wait_count_next = wait_count_reg;
        q_push          = 1'b0;
        q_job.kind      = csfs_pkg::KIND_START;
        if (accept) begin
            case (s_tuser)
                csfs_pkg::ACT_START: begin
                    if (phase_reg == PH_IDLE) begin
                        sum_next = csfs_pkg::HDR_BYTE + s_tdata;
                        q_push   = 1'b1;
                        if (s_tdata == '0) begin
                            q_job.kind      = csfs_pkg::KIND_START_ZERO;
                            bytes_left_next = '0;
                            phase_next      = PH_WAIT;
                            wait_count_next = '0;
                        end else begin
                            q_job.kind      = csfs_pkg::KIND_START;
                            bytes_left_next = s_tdata;
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                end
                csfs_pkg::ACT_PAYLOAD: begin
                    if (phase_reg == PH_PAYLOAD) begin
                        sum_next        = sum_reg + s_tdata;
                        bytes_left_next = bytes_left_reg - 1'b1;
                        q_push          = 1'b1;
                        if (bytes_left_next == '0) begin
                            q_job.kind      = csfs_pkg::KIND_PAYLOAD_LAST;
                            phase_next      = PH_WAIT;
                            wait_count_next = '0;
                        end else begin
                            q_job.kind = csfs_pkg::KIND_PAYLOAD;
                        end
                    end
                end
                csfs_pkg::ACT_RECV: begin
                    if (phase_reg == PH_WAIT && s_tdata == csfs_pkg::ACK_BYTE) begin
                        q_push     = 1'b1;
                        q_job.kind = csfs_pkg::KIND_ACK;
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    // Idle tick: advance the saturating wait counter.
                    if (phase_reg == PH_WAIT) begin
                        wait_count_next = wait_inc;
                        if (wait_inc >= timeout_reg) begin
                            q_push     = 1'b1;
                            q_job.kind = csfs_pkg::KIND_TIMEOUT;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            endcase
        end
        q_job.data = s_tdata;
        q_job.sum  = sum_next;
    end

    // Frame state and timeout register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            sum_reg        <= '0;
            wait_count_reg <= '0;
            timeout_reg    <= csfs_pkg::TIMEOUT_RESET;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            wait_count_reg <= wait_count_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // The phase never takes the unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("front phase holds an unused code");

    // A job is queued only while the queue has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_ready)
        else $error("front queued a job without room");

    // Leaving the payload phase for the wait phase restarts the timer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD && phase_next == PH_WAIT) |=> wait_count_reg == '0)
        else $error("wait counter not cleared on entering the wait phase");

endmodule

`default_nettype wire

>>> sv/csfs_queue.sv
// Short job queue between the front end and the back end of the sender.
// Register-based circular buffer; uses csfs_pkg for the job record.
`default_nettype none

module csfs_queue #(
    parameter int unsigned DEPTH = csfs_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire csfs_pkg::job_t  push_job,
    output logic                 ready,
    input  wire logic            pop,
    output logic                 head_valid,
    output csfs_pkg::job_t       head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    csfs_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign ready      = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // No pop from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job queue popped while empty");

    // The fill count never passes the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("job queue count out of range");

    // Equal pointers mean empty or full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg == rd_ptr_reg) |-> (count_reg == '0 || count_reg == CNT_FULL))
        else $error("job queue pointers and count disagree");

endmodule

`default_nettype wire

>>> sv/csfs_back.sv
// Back end of the sender: expands each queued job into one to three results
// and holds them in the output register. Uses csfs_pkg.
`default_nettype none

module csfs_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            head_valid,
    input  wire csfs_pkg::job_t                  head_job,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [csfs_pkg::BYTE_W-1:0]          m_tdata,
    output logic [csfs_pkg::STATUS_W:0]          m_tuser,
    output logic                                 m_tlast
);

    logic [csfs_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          out_valid_reg;
    logic [csfs_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          out_txv_reg;
    logic [csfs_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_last_reg;

    logic                          load;
    logic                          r_txv;
    logic [csfs_pkg::BYTE_W-1:0]   r_byte;
    logic [csfs_pkg::STATUS_W-1:0] r_status;
    logic                          r_last;

    // Result for the current step of the head job.
    always_comb begin
        r_txv    = 1'b1;
        r_byte   = head_job.data;
        r_status = csfs_pkg::ST_NONE;
        r_last   = 1'b1;
        case (head_job.kind)
            csfs_pkg::KIND_START: begin
                r_byte = (step_reg == '0) ? csfs_pkg::HDR_BYTE : head_job.data;
                r_last = (step_reg != '0);
            end
            csfs_pkg::KIND_START_ZERO: begin
                case (step_reg)
                    2'd0:    r_byte = csfs_pkg::HDR_BYTE;
                    2'd1:    r_byte = head_job.data;
                    default: r_byte = head_job.sum;
                endcase
                r_last = (step_reg == 2'd2);
            end
            csfs_pkg::KIND_PAYLOAD: begin
                r_byte = head_job.data;
            end
            csfs_pkg::KIND_PAYLOAD_LAST: begin
                r_byte = (step_reg == '0) ? head_job.data : head_job.sum;
                r_last = (step_reg != '0);
            end
            csfs_pkg::KIND_ACK: begin
                r_txv    = 1'b0;
                r_byte   = '0;
                r_status = csfs_pkg::ST_ACK;
            end
            csfs_pkg::KIND_TIMEOUT: begin
                r_txv    = 1'b0;
                r_byte   = '0;
                r_status = csfs_pkg::ST_TIMEOUT;
            end
            default: begin
                r_txv  = 1'b0;
                r_byte = '0;
            end
        endcase
    end

    // Step through the job whenever the output register can take a result.
    assign load = head_valid && (!out_valid_reg || m_tready);
    assign pop  = load && r_last;

    always_comb begin
        step_next = step_reg;
        if (pop) begin
            step_next = '0;
        end else if (load) begin
            step_next = step_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg   <= r_byte;
            out_txv_reg    <= r_txv;
            out_status_reg <= r_status;
            out_last_reg   <= r_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_status_reg, out_txv_reg};
    assign m_tlast  = out_last_reg;

    // A job never runs past its third result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != 2'd3)
        else $error("result step ran past the third result");

    // A status result carries no transmit byte and closes its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != csfs_pkg::ST_NONE) |->
        (!out_txv_reg && out_last_reg))
        else $error("status result is malformed");

    // The step only advances while a job sits at the head.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != '0) |-> head_valid)
        else $error("result step set with no job at the head");

endmodule

`default_nettype wire

>>> sv/checksum_frame_sender_with_ack_unit.sv
// Top level of the checksum frame sender with acknowledge wait.
// Joins csfs_front, csfs_queue and csfs_back; uses csfs_pkg.
//
//  Channel   Direction  Payload
//  s_*       in         tdata: data[7:0]; tuser: action[1:0]
//  m_*       out        tdata: tx_byte[7:0]; tuser: tx_valid[0], status[2:1]; tlast: last
//  cfg_*     in         cfg_wdata: ack_timeout[15:0], taken when cfg_we is high
//
// The front takes one request per cycle and updates the frame state at once.
// Each request gives zero to three results; the back drains one result per
// cycle unless m_tready holds it off, and a start request gives up to three results.
// A job queue of QUEUE_DEPTH entries lets requests keep flowing while the
// output is stalled; s_tready drops only when that queue is full.
// Reset is synchronous on aresetn and clears all control state.
`default_nettype none

module checksum_frame_sender_with_ack_unit #(
    parameter int unsigned QUEUE_DEPTH = csfs_pkg::QUEUE_DEPTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [csfs_pkg::BYTE_W-1:0]      s_tdata,   // data[7:0]
    input  wire logic [csfs_pkg::ACTION_W-1:0]    s_tuser,   // action[1:0]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [csfs_pkg::BYTE_W-1:0]           m_tdata,   // tx_byte[7:0]
    output logic [csfs_pkg::STATUS_W:0]           m_tuser,   // tx_valid[0], status[2:1]
    output logic                                  m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [csfs_pkg::TIMEOUT_W-1:0]   cfg_wdata
);

    logic           q_ready;
    logic           q_push;
    csfs_pkg::job_t q_job;
    logic           q_pop;
    logic           q_head_valid;
    csfs_pkg::job_t q_head_job;

    // Request classification and frame state.
    csfs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Job queue.
    csfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // Result generation and output register.
    csfs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking bench for checksum_frame_sender_with_ack_unit: drives framed requests,
// predicts every transmit byte and every acknowledge or timeout report, and checks them.
// Depends on csfs_pkg and the block's RTL only.
`default_nettype none

module tb_top;

    // Phases of the frame protocol as the predictor tracks them.
    typedef enum logic [1:0] {FR_IDLE, FR_PAYLOAD, FR_WAIT} frame_phase_t;

    // One result word of the block.
    typedef struct packed {
        logic                          tx_valid;
        logic [csfs_pkg::BYTE_W-1:0]   tx_byte;
        logic [csfs_pkg::STATUS_W-1:0] status;
        logic                          last;
    } tx_result_t;

    // Predicts the results of each accepted request and checks the block's output.
    class frame_scoreboard_t;
        logic [csfs_pkg::TIMEOUT_W-1:0] ack_timeout;
        frame_phase_t                   phase;
        logic [csfs_pkg::BYTE_W-1:0]    bytes_left;
        logic [csfs_pkg::BYTE_W-1:0]    running_sum;
        logic [csfs_pkg::TIMEOUT_W-1:0] wait_count;
        tx_result_t                     expected_q[$];
        int unsigned                    errors, results_seen, frames, acks, timeouts;

        function new();
            ack_timeout = csfs_pkg::TIMEOUT_RESET;
            phase       = FR_IDLE;
            bytes_left  = '0;
            running_sum = '0;
            wait_count  = '0;
        endfunction

        function void set_timeout(logic [csfs_pkg::TIMEOUT_W-1:0] value);
            ack_timeout = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic v, logic [csfs_pkg::BYTE_W-1:0] b,
                                  logic [csfs_pkg::STATUS_W-1:0] s, logic l);
            tx_result_t r;
            r.tx_valid = v;
            r.tx_byte  = b;
            r.status   = s;
            r.last     = l;
            expected_q.push_back(r);
        endfunction

        // Updates the frame state for one accepted request; returns 0 when it was ignored.
        function bit note_request(logic [csfs_pkg::ACTION_W-1:0] act,
                                  logic [csfs_pkg::BYTE_W-1:0] dat);
            case (act)
                csfs_pkg::ACT_START: begin
                    if (phase != FR_IDLE) return 1'b0;
                    frames++;
                    running_sum = csfs_pkg::HDR_BYTE + dat;
                    push_result(1'b1, csfs_pkg::HDR_BYTE, csfs_pkg::ST_NONE, 1'b0);
                    if (dat == '0) begin
                        // An empty frame sends its checksum right after the length.
                        push_result(1'b1, dat, csfs_pkg::ST_NONE, 1'b0);
                        push_result(1'b1, running_sum, csfs_pkg::ST_NONE, 1'b1);
                        bytes_left = '0;
                        wait_count = '0;
                        phase      = FR_WAIT;
                    end else begin
                        push_result(1'b1, dat, csfs_pkg::ST_NONE, 1'b1);
                        bytes_left = dat;
                        phase      = FR_PAYLOAD;
                    end
                end
                csfs_pkg::ACT_PAYLOAD: begin
                    if (phase != FR_PAYLOAD) return 1'b0;
                    running_sum = running_sum + dat;
                    bytes_left  = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        push_result(1'b1, dat, csfs_pkg::ST_NONE, 1'b0);
                        push_result(1'b1, running_sum, csfs_pkg::ST_NONE, 1'b1);
                        wait_count = '0;
                        phase      = FR_WAIT;
                    end else begin
                        push_result(1'b1, dat, csfs_pkg::ST_NONE, 1'b1);
                    end
                end
                csfs_pkg::ACT_RECV: begin
                    // Only an acknowledge byte matters while waiting.
                    if (phase != FR_WAIT || dat != csfs_pkg::ACK_BYTE) return 1'b0;
                    push_result(1'b0, '0, csfs_pkg::ST_ACK, 1'b1);
                    acks++;
                    phase = FR_IDLE;
                end
                default: begin
                    if (phase != FR_WAIT) return 1'b0;
                    if (wait_count != '1) wait_count = wait_count + 1'b1;
                    if (wait_count >= ack_timeout) begin
                        push_result(1'b0, '0, csfs_pkg::ST_TIMEOUT, 1'b1);
                        timeouts++;
                        phase = FR_IDLE;
                    end
                end
            endcase
            return 1'b1;
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(tx_result_t got);
            tx_result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("Unexpected result: tx_valid %0b tx_byte %02h status %0d last %0b",
                       got.tx_valid, got.tx_byte, got.status, got.last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.tx_valid !== want.tx_valid) begin
                $error("tx_valid: expected %0b, got %0b", want.tx_valid, got.tx_valid);
                errors++;
            end
            if (got.tx_byte !== want.tx_byte) begin
                $error("tx_byte: expected %02h, got %02h", want.tx_byte, got.tx_byte);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [csfs_pkg::BYTE_W-1:0]     s_tdata   = '0;   // data[7:0]
    logic [csfs_pkg::ACTION_W-1:0]   s_tuser   = '0;   // action[1:0]
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [csfs_pkg::BYTE_W-1:0]     m_tdata;          // tx_byte[7:0]
    logic [csfs_pkg::STATUS_W:0]     m_tuser;          // tx_valid[0], status[2:1]
    logic                            m_tlast;
    logic                            cfg_we    = 1'b0;
    logic [csfs_pkg::TIMEOUT_W-1:0]  cfg_wdata = '0;

    frame_scoreboard_t sb = new();

    bit          sender_gaps   = 1'b1;
    bit          receiver_gaps = 1'b1;
    bit          last_effective;
    int unsigned stall_cycles  = 0;

    checksum_frame_sender_with_ack_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Receiver: random back-pressure, or a long hold-off while stall_cycles runs down.
    always @(posedge aclk) begin
        if (stall_cycles != 0) begin
            m_tready     <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else begin
            m_tready <= !(receiver_gaps && $urandom_range(99) < 12);
        end
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tuser[0], m_tdata, m_tuser[csfs_pkg::STATUS_W:1], m_tlast});
    end

    // Offers one request, with a random gap first, and records it once accepted.
    task automatic send_request(input logic [csfs_pkg::ACTION_W-1:0] act,
                                input logic [csfs_pkg::BYTE_W-1:0] dat);
        if (sender_gaps && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= dat;
        do @(posedge aclk); while (!s_tready);
        last_effective = sb.note_request(act, dat);
    endtask

    // Stops offering, waits for all expected results, then lets the pipeline empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        for (int i = 0; i < 4000 && sb.pending() != 0; i++) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors += sb.pending();
            sb.expected_q.delete();
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [csfs_pkg::TIMEOUT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_timeout(value);
    endtask

    // Mostly well-formed frames and acknowledge waits with random content, some noise.
    task automatic random_phase(input int unsigned goal);
        int unsigned                    done;
        int unsigned                    roll;
        logic [csfs_pkg::ACTION_W-1:0]  act;
        logic [csfs_pkg::BYTE_W-1:0]    dat;
        done = 0;
        while (done < goal) begin
            roll = $urandom_range(99);
            act  = 2'($urandom_range(3));
            dat  = 8'($urandom_range(255));
            case (sb.phase)
                FR_IDLE: begin
                    if (roll < 88) begin
                        act  = csfs_pkg::ACT_START;
                        roll = $urandom_range(99);
                        if (roll < 55)      dat = 8'($urandom_range(4));
                        else if (roll < 85) dat = 8'($urandom_range(16, 5));
                        else if (roll < 97) dat = 8'($urandom_range(60, 17));
                        else                dat = 8'hFF;
                    end
                end
                FR_PAYLOAD: begin
                    if (roll < 92) act = csfs_pkg::ACT_PAYLOAD;
                end
                default: begin
                    if (roll < 25) begin
                        act = csfs_pkg::ACT_RECV;
                        dat = csfs_pkg::ACK_BYTE;
                    end else if (roll < 45) begin
                        act = csfs_pkg::ACT_RECV;
                    end else if (roll < 95) begin
                        act = csfs_pkg::ACT_TICK;
                    end
                end
            endcase
            send_request(act, dat);
            if (last_effective) done++;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Requests in the wrong phase, an empty frame, stray bytes, then an acknowledge.
        send_request(csfs_pkg::ACT_TICK, 8'h00);
        send_request(csfs_pkg::ACT_RECV, csfs_pkg::ACK_BYTE);
        send_request(csfs_pkg::ACT_PAYLOAD, 8'h55);
        send_request(csfs_pkg::ACT_START, 8'h00);
        send_request(csfs_pkg::ACT_START, 8'h05);
        send_request(csfs_pkg::ACT_PAYLOAD, 8'hAA);
        send_request(csfs_pkg::ACT_RECV, 8'h00);
        send_request(csfs_pkg::ACT_RECV, 8'hFF);
        send_request(csfs_pkg::ACT_RECV, csfs_pkg::ACK_BYTE);

        // Two-byte frame with extreme bytes, a few idle ticks well under the reset
        // limit, then an acknowledge.
        send_request(csfs_pkg::ACT_START, 8'h02);
        send_request(csfs_pkg::ACT_START, 8'hFF);
        send_request(csfs_pkg::ACT_RECV, csfs_pkg::ACK_BYTE);
        send_request(csfs_pkg::ACT_TICK, 8'hFF);
        send_request(csfs_pkg::ACT_PAYLOAD, 8'hFF);
        send_request(csfs_pkg::ACT_PAYLOAD, 8'h00);
        send_request(csfs_pkg::ACT_RECV, 8'h07);
        repeat (4) send_request(csfs_pkg::ACT_TICK, 8'hFF);
        send_request(csfs_pkg::ACT_RECV, csfs_pkg::ACK_BYTE);

        // A longer frame; the checksum wraps.
        send_request(csfs_pkg::ACT_START, 8'h10);
        repeat (16) send_request(csfs_pkg::ACT_PAYLOAD, 8'($urandom_range(255)));
        send_request(csfs_pkg::ACT_RECV, csfs_pkg::ACK_BYTE);
        drain_results();

        // A zero limit fails on the first idle tick.
        write_timeout(16'd0);
        send_request(csfs_pkg::ACT_START, 8'h01);
        send_request(csfs_pkg::ACT_PAYLOAD, 8'h80);
        send_request(csfs_pkg::ACT_TICK, 8'h00);
        drain_results();

        // With a limit of one, an acknowledge before the tick still wins.
        write_timeout(16'd1);
        send_request(csfs_pkg::ACT_START, 8'h00);
        send_request(csfs_pkg::ACT_RECV, csfs_pkg::ACK_BYTE);
        send_request(csfs_pkg::ACT_START, 8'h00);
        send_request(csfs_pkg::ACT_TICK, 8'h00);
        drain_results();

        // Largest limit; a few idle ticks stay far below it and the acknowledge wins.
        write_timeout(16'hFFFF);
        send_request(csfs_pkg::ACT_START, 8'h03);
        repeat (3) send_request(csfs_pkg::ACT_PAYLOAD, 8'($urandom_range(255)));
        repeat (6) send_request(csfs_pkg::ACT_TICK, 8'($urandom_range(255)));
        send_request(csfs_pkg::ACT_RECV, csfs_pkg::ACK_BYTE);
        drain_results();

        // Random traffic over several limits; the second phase opens with a long
        // output hold-off, the third runs with no gaps on either side.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_timeout(16'd3);
                1: write_timeout(16'd1);
                2: write_timeout(16'hFFFF);
                3: write_timeout(16'($urandom_range(40, 1)));
                4: write_timeout(16'd2);
                default: write_timeout(16'($urandom_range(16'hFFFF, 1)));
            endcase
            sender_gaps   = (p != 2);
            receiver_gaps = (p != 2);
            if (p == 1) stall_cycles <= 80;
            random_phase(32);
            drain_results();
        end

        $display("Covered %0d frames, %0d acknowledges and %0d timeouts; %0d results checked.",
                 sb.frames, sb.acks, sb.timeouts, sb.results_seen);
        $display("Limits from zero to the maximum, random gaps on both sides, one hold-off.");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
sv/csfs_pkg.sv
sv/csfs_front.sv
sv/csfs_queue.sv
sv/csfs_back.sv
sv/checksum_frame_sender_with_ack_unit.sv
dv/tb_top.sv
